/* rtl/expression_token_lexer_unit_defines.svh */
// Assertion helpers used by the lexer's token queue.
`ifndef EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ETL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etl assertion failed");

// Next-cycle implication, disabled while in reset.
`define ETL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etl assertion failed");

`endif

/* rtl/etl_pkg.sv */
package etl_pkg;

    localparam int CH_W    = 8;
    localparam int KIND_W  = 4;
    localparam int START_W = 16;
    localparam int LEN_W   = 8;
    localparam int LEN_MAX = 255;

    // Token queue geometry
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    // Characters with a meaning of their own
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CH_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_HT    = 8'h09;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;

    typedef enum logic [KIND_W-1:0] {
        KIND_END      = 4'd0,
        KIND_NUMBER   = 4'd1,
        KIND_IDENT    = 4'd2,
        KIND_OPERATOR = 4'd3,
        KIND_ASSIGN   = 4'd4,
        KIND_SEMI     = 4'd5,
        KIND_LPAREN   = 4'd6,
        KIND_RPAREN   = 4'd7,
        KIND_ERROR    = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_NUMBER  = 2'd1,
        MODE_IDENT   = 2'd2,
        MODE_STOPPED = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic [CH_W-1:0]     chr;
        logic                last;
    } token_t;

    // Front to queue: up to two tokens per character
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_FF) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_HT) || (c == CH_VT);
    endfunction

    // Kind of a single-character token; anything unknown is an error
    function automatic kind_t punct_kind(input logic [CH_W-1:0] c);
        kind_t k;
        unique case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: k = KIND_OPERATOR;
            CH_EQ:   k = KIND_ASSIGN;
            CH_SEMI: k = KIND_SEMI;
            CH_LPAR: k = KIND_LPAREN;
            CH_RPAR: k = KIND_RPAREN;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

/* rtl/expression_token_lexer_unit.sv */
// Streaming expression lexer: one source byte per word on the input, one token per word on
// the output. Input words are taken at one per cycle; a byte that closes an open number or
// identifier and is itself a token gives two output words, which leave one per cycle while
// out_ready is high, so the input stalls only when the four-entry token queue has fewer
// than two free slots. A byte's tokens are written into the queue when the byte is taken,
// and the output register loads them from the queue in order when it is empty or being read.
// Lengths saturate at MAX_TOKEN_LEN (capped at 255); start offsets are the low 16 bits of a
// POS_WIDTH-bit position that wraps and returns to zero at each NUL. After an error token
// every byte is consumed with no output until reset.
module expression_token_lexer_unit
    import etl_pkg::*;
#(
    parameter int POS_WIDTH     = 16,
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CH_W-1:0]    ch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  token_kind,
    output logic [START_W-1:0] start_offset,
    output logic [LEN_W-1:0]   token_length,
    output logic [CH_W-1:0]    token_char,
    output logic               last_of_step
);

    localparam int LEN_LIMIT = (MAX_TOKEN_LEN < LEN_MAX) ? MAX_TOKEN_LEN : LEN_MAX;

    push_t  push;
    logic   room;
    logic   pop;
    logic   head_valid;
    token_t head;

    // Classify bytes and track open tokens
    etl_front #(
        .POS_WIDTH (POS_WIDTH),
        .LEN_LIMIT (LEN_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ch       (ch),
        .room     (room),
        .push     (push)
    );

    // Decouple the two-token bursts from the output
    etl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Output register
    etl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .token_char   (token_char),
        .last_of_step (last_of_step)
    );

endmodule

/* rtl/etl_front.sv */
module etl_front
    import etl_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int LEN_LIMIT = 255
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CH_W-1:0] ch,
    input  logic            room,
    output push_t           push
);

    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] ostart_reg, ostart_next;
    logic [LEN_W-1:0]     olen_reg, olen_next;

    logic  accept, active;
    logic  dig, let_c, extend, closing, is_end, single;
    kind_t pk;

    // Take a character whenever the queue can hold both possible tokens
    assign in_ready = room;
    assign accept   = in_valid && room;
    assign active   = accept && (mode_reg != MODE_STOPPED);

    // Classification
    assign dig     = is_digit(ch);
    assign let_c   = is_letter(ch);
    assign pk      = punct_kind(ch);
    assign is_end  = (ch == CH_NUL);
    assign single  = !dig && !let_c && !is_end && !is_space(ch);
    assign extend  = ((mode_reg == MODE_NUMBER) && dig) ||
                     ((mode_reg == MODE_IDENT) && (dig || let_c));
    assign closing = (mode_reg == MODE_NUMBER) || (mode_reg == MODE_IDENT);

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (active)
        begin
            priority if (extend)
                mode_next = mode_reg;
            else if (is_end)
                mode_next = MODE_IDLE;
            else if (dig)
                mode_next = MODE_NUMBER;
            else if (let_c)
                mode_next = MODE_IDENT;
            else if (single && (pk == KIND_ERROR))
                mode_next = MODE_STOPPED;
            else
                mode_next = MODE_IDLE;
        end
    end

    // Tokens and running position
    always_comb
    begin
        token_t tok_close;
        token_t tok_char;
        logic   has_char;

        pos_next    = pos_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        push        = '0;

        has_char        = is_end || single;
        tok_close.kind  = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        tok_close.start = START_W'(ostart_reg);
        tok_close.len   = olen_reg;
        tok_close.chr   = '0;
        tok_close.last  = !has_char;

        tok_char.kind   = is_end ? KIND_END : pk;
        tok_char.start  = START_W'(pos_reg);
        tok_char.len    = is_end ? LEN_W'(0) : LEN_W'(1);
        tok_char.chr    = is_end ? '0 : ch;
        tok_char.last   = 1'b1;

        if (active)
        begin
            if (extend)
            begin
                if (olen_reg < LEN_W'(LEN_LIMIT))
                    olen_next = olen_reg + LEN_W'(1);
                pos_next = pos_reg + POS_WIDTH'(1);
            end
            else
            begin
                if (closing)
                begin
                    push.tok0 = tok_close;
                    push.tok1 = tok_char;
                    push.cnt  = has_char ? 2'd2 : 2'd1;
                end
                else
                begin
                    push.tok0 = tok_char;
                    push.cnt  = has_char ? 2'd1 : 2'd0;
                end

                if (is_end)
                begin
                    pos_next    = '0;
                    ostart_next = '0;
                    olen_next   = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_WIDTH'(1);
                    if (dig || let_c)
                    begin
                        ostart_next = pos_reg;
                        olen_next   = LEN_W'(1);
                    end
                    else if (closing)
                        olen_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            ostart_reg <= '0;
            olen_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            ostart_reg <= ostart_next;
            olen_reg   <= olen_next;
        end
    end

endmodule

/* rtl/etl_queue.sv */
`include "expression_token_lexer_unit_defines.svh"

module etl_queue
    import etl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   room,
    input  logic   pop,
    output logic   head_valid,
    output token_t head
);

    token_t            mem [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Room for the worst case of two words from one character
    assign room       = count_reg <= QCNT_W'(QDEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + QIDX_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + QIDX_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.tok0;
        if (push.cnt == 2'd2)
            mem[wr_ptr_reg + QIDX_W'(1)] <= push.tok1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ETL_ASSERT_NOW(q_no_overflow, push.cnt != 2'd0, (count_reg + QCNT_W'(push.cnt)) <= QCNT_W'(QDEPTH))
    `ETL_ASSERT_NOW(q_no_underflow, pop, count_reg != '0)
    `ETL_ASSERT_NOW(q_ptr_match, 1'b1, QIDX_W'(count_reg) == QIDX_W'(wr_ptr_reg - rd_ptr_reg))
    `ETL_ASSERT_NEXT(q_push_visible, (push.cnt != 2'd0) && !pop, count_reg != '0)

endmodule

/* rtl/etl_back.sv */
module etl_back
    import etl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  token_t             head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  token_kind,
    output logic [START_W-1:0] start_offset,
    output logic [LEN_W-1:0]   token_length,
    output logic [CH_W-1:0]    token_char,
    output logic               last_of_step
);

    logic   out_valid_reg, out_valid_next;
    token_t out_tok_reg;

    // Refill the output register when it is empty or being taken
    assign pop            = head_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_tok_reg <= head;
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = out_tok_reg.kind;
    assign start_offset = out_tok_reg.start;
    assign token_length = out_tok_reg.len;
    assign token_char   = out_tok_reg.chr;
    assign last_of_step = out_tok_reg.last;

endmodule

/* verif/lexer_token_checker.sv */
// Watches both channels of the lexer, predicts the token words that each
// accepted source byte causes and compares them in order with the words
// that leave the block.
module lexer_token_checker
    import etl_pkg::*;
#(
    parameter int POS_WIDTH     = 16,
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [CH_W-1:0]    ch,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [KIND_W-1:0]  token_kind,
    input  logic [START_W-1:0] start_offset,
    input  logic [LEN_W-1:0]   token_length,
    input  logic [CH_W-1:0]    token_char,
    input  logic               last_of_step,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 words_checked
);

    localparam int LEN_CAP     = (MAX_TOKEN_LEN < LEN_MAX) ? MAX_TOKEN_LEN : LEN_MAX;
    localparam int MAX_REPORTS = 10;

    // Predicted lexer state
    mode_t                scan_mode;
    logic [POS_WIDTH-1:0] scan_pos;
    logic [POS_WIDTH-1:0] tok_start;
    logic [LEN_W-1:0]     tok_len;

    // Token words predicted but not yet seen on the output
    token_t expected_tokens[$];

    function automatic logic is_numeral(input logic [CH_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return c inside {CH_SPACE, CH_FF, CH_LF, CH_CR, CH_HT, CH_VT};
    endfunction

    task automatic emit(input kind_t k, input logic [POS_WIDTH-1:0] at,
                        input logic [LEN_W-1:0] n, input logic [CH_W-1:0] c);
        token_t t;
        t.kind  = k;
        t.start = START_W'(at);
        t.len   = n;
        t.chr   = c;
        t.last  = 1'b0;
        expected_tokens.push_back(t);
    endtask

    // Advance the predicted state by one source byte, queueing its tokens
    task automatic lex_byte(input logic [CH_W-1:0] c);
        int     first_new;
        token_t t;
        kind_t  k;
        first_new = expected_tokens.size();
        k = KIND_ERROR;
        if (scan_mode == MODE_STOPPED)
            return;

        // byte extends the open token
        if ((scan_mode == MODE_NUMBER && is_numeral(c)) ||
            (scan_mode == MODE_IDENT && (is_numeral(c) || is_alpha(c))))
        begin
            if (tok_len < LEN_CAP)
                tok_len = tok_len + 1'b1;
            scan_pos = scan_pos + 1'b1;
            return;
        end

        // anything else closes it first
        if (scan_mode == MODE_NUMBER || scan_mode == MODE_IDENT)
        begin
            emit(scan_mode == MODE_NUMBER ? KIND_NUMBER : KIND_IDENT, tok_start, tok_len, '0);
            scan_mode = MODE_IDLE;
            tok_len   = '0;
        end

        if (c == CH_NUL)
        begin
            // end of source: position starts over
            emit(KIND_END, scan_pos, '0, '0);
            scan_pos  = '0;
            tok_start = '0;
        end
        else
        begin
            if (is_numeral(c) || is_alpha(c))
            begin
                scan_mode = is_numeral(c) ? MODE_NUMBER : MODE_IDENT;
                tok_start = scan_pos;
                tok_len   = 8'd1;
            end
            else if (!is_blank(c))
            begin
                case (c)
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: k = KIND_OPERATOR;
                    CH_EQ:   k = KIND_ASSIGN;
                    CH_SEMI: k = KIND_SEMI;
                    CH_LPAR: k = KIND_LPAREN;
                    CH_RPAR: k = KIND_RPAREN;
                    default:
                    begin
                        // unknown byte stops the lexer for good
                        k = KIND_ERROR;
                        scan_mode = MODE_STOPPED;
                    end
                endcase
                emit(k, scan_pos, 8'd1, c);
            end
            scan_pos = scan_pos + 1'b1;
        end

        // mark the last word of this byte
        if (expected_tokens.size() > first_new)
        begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        token_t want;
        token_t got;
        if (!rst_n)
        begin
            scan_mode = MODE_IDLE;
            scan_pos  = '0;
            tok_start = '0;
            tok_len   = '0;
            expected_tokens.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
            words_checked  <= 0;
        end
        else
        begin
            // predict before comparing so a same-edge word is never missed
            if (in_valid && in_ready)
                lex_byte(ch);

            if (out_valid && out_ready)
            begin
                got.kind  = kind_t'(token_kind);
                got.start = start_offset;
                got.len   = token_length;
                got.chr   = token_char;
                got.last  = last_of_step;
                if (expected_tokens.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected token word: kind %0d start %0d len %0d char %02h last %0b",
                                 got.kind, got.start, got.len, got.chr, got.last);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.kind !== want.kind || got.start !== want.start ||
                        got.len !== want.len || got.chr !== want.chr || got.last !== want.last)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                        begin
                            $display("token word %0d differs:", words_checked);
                            $display("  expected kind %0d start %0d len %0d char %02h last %0b",
                                     want.kind, want.start, want.len, want.chr, want.last);
                            $display("  actual   kind %0d start %0d len %0d char %02h last %0b",
                                     got.kind, got.start, got.len, got.chr, got.last);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                    words_checked <= words_checked + 1;
                end
            end
            pending_count <= expected_tokens.size();
        end
    end

endmodule

/* verif/testbench.sv */
module testbench;
    import etl_pkg::*;

    localparam int RANDOM_BYTES = 1400;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [CH_W-1:0]    ch        = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] start_offset;
    logic [LEN_W-1:0]   token_length;
    logic [CH_W-1:0]    token_char;
    logic               last_of_step;

    int mismatch_count;
    int pending_count;
    int words_checked;
    int bytes_sent = 0;
    bit steady     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    expression_token_lexer_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .token_char   (token_char),
        .last_of_step (last_of_step)
    );

    lexer_token_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ch             (ch),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .start_offset   (start_offset),
        .token_length   (token_length),
        .token_char     (token_char),
        .last_of_step   (last_of_step),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .words_checked  (words_checked)
    );

    // Random source bytes, all of them known to the lexer
    function automatic logic [CH_W-1:0] rand_digit();
        return CH_W'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [CH_W-1:0] rand_letter();
        if ($urandom_range(0, 1))
            return CH_W'($urandom_range(8'h41, 8'h5A));
        return CH_W'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [CH_W-1:0] rand_alnum();
        return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [CH_W-1:0] rand_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_FF;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_HT;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] rand_operator();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] rand_legal();
        case ($urandom_range(0, 9))
            0: return CH_NUL;
            1, 2: return rand_digit();
            3, 4: return rand_letter();
            5: return rand_blank();
            6: return rand_operator();
            7: return ($urandom_range(0, 1)) ? CH_EQ : CH_SEMI;
            default: return ($urandom_range(0, 1)) ? CH_LPAR : CH_RPAR;
        endcase
    endfunction

    // One byte on the input channel, after a random idle gap
    task automatic send_byte(input logic [CH_W-1:0] c);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_blanks();
        repeat ($urandom_range(0, 5) / 2) send_byte(rand_blank());
    endtask

    task automatic send_number();
        repeat ($urandom_range(1, 6)) send_byte(rand_digit());
    endtask

    task automatic send_name();
        send_byte(rand_letter());
        repeat ($urandom_range(0, 6)) send_byte(rand_alnum());
    endtask

    task automatic send_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_number();
            5, 6, 7, 8: send_name();
            default:
            begin
                send_byte(CH_LPAR);
                send_name();
                send_blanks();
                send_byte(rand_operator());
                send_blanks();
                send_number();
                send_byte(CH_RPAR);
            end
        endcase
    endtask

    // name = operand { op operand } ;
    task automatic send_statement();
        send_name();
        send_blanks();
        send_byte(CH_EQ);
        send_blanks();
        send_operand();
        repeat ($urandom_range(0, 3))
        begin
            send_blanks();
            send_byte(rand_operator());
            send_blanks();
            send_operand();
        end
        send_blanks();
        send_byte(CH_SEMI);
        if ($urandom_range(0, 3) == 0)
            send_byte(CH_NUL);
        else
            send_byte(rand_blank());
    endtask

    task automatic send_broken();
        case ($urandom_range(0, 3))
            0:
            begin
                // letters right after digits
                send_number();
                send_name();
            end
            1:
            begin
                // source ends inside a token
                send_name();
                send_byte(CH_NUL);
            end
            2:
            begin
                send_byte(CH_RPAR);
                send_byte(rand_operator());
                send_byte(rand_operator());
                send_byte(CH_LPAR);
            end
            default:
            begin
                send_number();
                send_byte(CH_NUL);
                send_byte(CH_NUL);
            end
        endcase
    endtask

    // Receiver: random stalls per word, one long hold-off to back up the block
    initial
    begin : receiver
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 7);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin : stimulus
        int stop_at;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every kind but error, field extremes, all blanks, digit/letter changes
        send_text("Za9=(10*z)/A-0;");
        send_byte(CH_HT);
        send_byte(CH_LF);
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_byte(CH_CR);
        send_byte(CH_SPACE);
        send_text("9a");
        send_byte(CH_NUL);

        // tokens long enough to saturate the length
        send_byte(rand_letter());
        repeat (299) send_byte(rand_alnum());
        send_byte(CH_SEMI);
        repeat (260) send_byte(rand_digit());
        send_byte(CH_NUL);

        // random: mostly statements, some noise and broken pieces
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                7, 8: repeat ($urandom_range(1, 6)) send_byte(rand_legal());
                9: send_broken();
                default: send_statement();
            endcase
        end
        send_byte(CH_NUL);

        // identifier with digits, then an operator and another name
        send_text("ab12+cd ");
        send_byte(CH_NUL);

        // unknown byte stops the lexer; what follows is ignored
        send_text("ok");
        send_byte(8'hFF);
        repeat (8) send_byte(CH_W'($urandom_range(0, 255)));
        send_byte(CH_NUL);
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d source bytes and %0d token words", bytes_sent, words_checked);
        $display("including all token kinds, saturated lengths, output stalls and stop on error");
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
